/* hw/rtl/ccirc_pkg.sv */
// Shared constants and types for the circumcircle pipeline.
`timescale 1ns / 1ps
`default_nettype none
package ccirc_pkg;

  // Status codes on the result.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_COLL  = 2'd1;
  localparam logic [1:0] ST_SMALL = 2'd2;
  localparam logic [1:0] ST_SAT   = 2'd3;

  // Configuration register indexes.
  localparam logic CFG_COLL_THR = 1'b0;
  localparam logic CFG_MIN_RAD  = 1'b1;

  localparam logic [31:0] COLL_THR_RESET = 32'd4295;
  localparam logic [31:0] MIN_RAD_RESET  = 32'd1;

  // Numerator width, divider remainder width, quotient bits, root bits.
  localparam int NW    = 101;
  localparam int RW    = 104;
  localparam int QBITS = 35;
  localparam int SBITS = 32;

  typedef struct packed {
    logic signed [31:0] x1;
    logic signed [31:0] y1;
    logic               coll;
    logic               negx;
    logic               negy;
    logic               ovfx;
    logic               ovfy;
  } div_side_t;

  typedef struct packed {
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic               sat;
    logic               coll;
    logic               radsat;
  } sqrt_side_t;

endpackage
`default_nettype wire

/* hw/rtl/circumcircle_from_three_points.sv */
// Pipelined circumcircle of three Q16.16 points: center, radius and status.
//
//   channel  | handshake        | payload
//   ---------+------------------+------------------------------------------------
//   input    | start, busy      | first_x/y, second_x/y, third_x/y
//   result   | done             | center_x, center_y, circle_radius, status
//   config   | cfg_we           | cfg_index, cfg_data
//
// One triple enters per cycle; busy stays low. Each triple leaves on a one-cycle done
// beat after the 35-stage quotient divider and the 32-stage square root, one bit per
// stage. Reset is synchronous; it clears the valid bits and loads the configuration
// registers with their reset values; no stalls occur since results are never held off.
`timescale 1ns / 1ps
`default_nettype none
module circumcircle_from_three_points
  import ccirc_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic signed [31:0] first_x,
  input  wire logic signed [31:0] first_y,
  input  wire logic signed [31:0] second_x,
  input  wire logic signed [31:0] second_y,
  input  wire logic signed [31:0] third_x,
  input  wire logic signed [31:0] third_y,
  input  wire logic               cfg_we,
  input  wire logic               cfg_index,
  input  wire logic [31:0]        cfg_data,
  output logic                    done,
  output logic signed [31:0]      center_x,
  output logic signed [31:0]      center_y,
  output logic [31:0]             circle_radius,
  output logic [1:0]              status
);

  logic [31:0] coll_thr;
  logic [31:0] min_rad;

  always_ff @(posedge clk) begin
    if (rst) begin
      coll_thr <= COLL_THR_RESET;
      min_rad  <= MIN_RAD_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_COLL_THR: coll_thr <= cfg_data;
        CFG_MIN_RAD:  min_rad  <= cfg_data;
      endcase
    end
  end

  assign busy = 1'b0;

  logic acc;
  assign acc = start & ~busy;

  // Stage 1: move the first point to the origin.
  logic               v1;
  logic signed [32:0] s1_ax, s1_ay, s1_bx, s1_by;
  logic signed [31:0] s1_x1, s1_y1;

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else     v1 <= acc;
    s1_ax <= 33'(second_x) - 33'(first_x);
    s1_ay <= 33'(second_y) - 33'(first_y);
    s1_bx <= 33'(third_x) - 33'(first_x);
    s1_by <= 33'(third_y) - 33'(first_y);
    s1_x1 <= first_x;
    s1_y1 <= first_y;
  end

  // Stage 2: the six products of the difference vectors.
  logic               v2;
  logic signed [65:0] s2_axby, s2_aybx, s2_axax, s2_ayay, s2_bxbx, s2_byby;
  logic signed [32:0] s2_ax, s2_ay, s2_bx, s2_by;
  logic signed [31:0] s2_x1, s2_y1;

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else     v2 <= v1;
    s2_axby <= s1_ax * s1_by;
    s2_aybx <= s1_ay * s1_bx;
    s2_axax <= s1_ax * s1_ax;
    s2_ayay <= s1_ay * s1_ay;
    s2_bxbx <= s1_bx * s1_bx;
    s2_byby <= s1_by * s1_by;
    s2_ax <= s1_ax;
    s2_ay <= s1_ay;
    s2_bx <= s1_bx;
    s2_by <= s1_by;
    s2_x1 <= s1_x1;
    s2_y1 <= s1_y1;
  end

  // Stage 3: determinant and squared lengths.
  logic               v3;
  logic signed [66:0] s3_det;
  logic [65:0]        s3_sa, s3_sb;
  logic signed [32:0] s3_ax, s3_ay, s3_bx, s3_by;
  logic signed [31:0] s3_x1, s3_y1;

  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else     v3 <= v2;
    s3_det <= 67'(s2_axby) - 67'(s2_aybx);
    s3_sa  <= $unsigned(s2_axax) + $unsigned(s2_ayay);
    s3_sb  <= $unsigned(s2_bxbx) + $unsigned(s2_byby);
    s3_ax <= s2_ax;
    s3_ay <= s2_ay;
    s3_bx <= s2_bx;
    s3_by <= s2_by;
    s3_x1 <= s2_x1;
    s3_y1 <= s2_y1;
  end

  // Stage 4: the wide products, with the squared lengths split in two halves.
  logic               v4;
  logic signed [66:0] p_bysa_l, p_bysa_h, p_aysb_l, p_aysb_h;
  logic signed [66:0] p_axsb_l, p_axsb_h, p_bxsa_l, p_bxsa_h;
  logic [66:0]        s4_adet;
  logic               s4_detneg;
  logic signed [31:0] s4_x1, s4_y1;
  logic signed [33:0] sa_l, sa_h, sb_l, sb_h;

  assign sa_l = $signed({1'b0, s3_sa[32:0]});
  assign sa_h = $signed({1'b0, s3_sa[65:33]});
  assign sb_l = $signed({1'b0, s3_sb[32:0]});
  assign sb_h = $signed({1'b0, s3_sb[65:33]});

  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else     v4 <= v3;
    p_bysa_l <= s3_by * sa_l;
    p_bysa_h <= s3_by * sa_h;
    p_aysb_l <= s3_ay * sb_l;
    p_aysb_h <= s3_ay * sb_h;
    p_axsb_l <= s3_ax * sb_l;
    p_axsb_h <= s3_ax * sb_h;
    p_bxsa_l <= s3_bx * sa_l;
    p_bxsa_h <= s3_bx * sa_h;
    s4_adet   <= s3_det[66] ? 67'(-s3_det) : 67'(s3_det);
    s4_detneg <= s3_det[66];
    s4_x1 <= s3_x1;
    s4_y1 <= s3_y1;
  end

  // Stage 5: recombine the halves; decide collinearity.
  logic                 v5;
  logic signed [NW-1:0] s5_bysa, s5_aysb, s5_axsb, s5_bxsa;
  logic [66:0]          s5_adet;
  logic                 s5_detneg, s5_coll;
  logic signed [31:0]   s5_x1, s5_y1;

  always_ff @(posedge clk) begin
    if (rst) v5 <= 1'b0;
    else     v5 <= v4;
    s5_bysa <= (NW'(p_bysa_h) <<< 33) + NW'(p_bysa_l);
    s5_aysb <= (NW'(p_aysb_h) <<< 33) + NW'(p_aysb_l);
    s5_axsb <= (NW'(p_axsb_h) <<< 33) + NW'(p_axsb_l);
    s5_bxsa <= (NW'(p_bxsa_h) <<< 33) + NW'(p_bxsa_l);
    s5_coll <= (s4_adet == '0) || (s4_adet < {35'd0, coll_thr});
    s5_adet   <= s4_adet;
    s5_detneg <= s4_detneg;
    s5_x1 <= s4_x1;
    s5_y1 <= s4_y1;
  end

  // Stage 6: the two numerators.
  logic                 v6;
  logic signed [NW-1:0] s6_numx, s6_numy;
  logic [66:0]          s6_adet;
  logic                 s6_detneg, s6_coll;
  logic signed [31:0]   s6_x1, s6_y1;

  always_ff @(posedge clk) begin
    if (rst) v6 <= 1'b0;
    else     v6 <= v5;
    s6_numx <= s5_bysa - s5_aysb;
    s6_numy <= s5_axsb - s5_bxsa;
    s6_adet   <= s5_adet;
    s6_detneg <= s5_detneg;
    s6_coll   <= s5_coll;
    s6_x1 <= s5_x1;
    s6_y1 <= s5_y1;
  end

  // Stage 7: magnitudes and quotient signs.
  logic               v7;
  logic [NW-1:0]      s7_anx, s7_any;
  logic [66:0]        s7_adet;
  logic               s7_negx, s7_negy, s7_coll;
  logic signed [31:0] s7_x1, s7_y1;

  always_ff @(posedge clk) begin
    if (rst) v7 <= 1'b0;
    else     v7 <= v6;
    s7_anx  <= s6_numx[NW-1] ? NW'(-s6_numx) : NW'(s6_numx);
    s7_any  <= s6_numy[NW-1] ? NW'(-s6_numy) : NW'(s6_numy);
    s7_negx <= s6_numx[NW-1] ^ s6_detneg;
    s7_negy <= s6_numy[NW-1] ^ s6_detneg;
    s7_adet <= s6_adet;
    s7_coll <= s6_coll;
    s7_x1 <= s6_x1;
    s7_y1 <= s6_y1;
  end

  // Stage 8: add half the divisor so that the quotient rounds to nearest.
  logic               v8;
  logic [NW-1:0]      s8_nx, s8_ny;
  logic [67:0]        s8_d2;
  logic               s8_negx, s8_negy, s8_coll;
  logic signed [31:0] s8_x1, s8_y1;

  always_ff @(posedge clk) begin
    if (rst) v8 <= 1'b0;
    else     v8 <= v7;
    s8_nx   <= s7_anx + NW'(s7_adet);
    s8_ny   <= s7_any + NW'(s7_adet);
    s8_d2   <= {s7_adet, 1'b0};
    s8_negx <= s7_negx;
    s8_negy <= s7_negy;
    s8_coll <= s7_coll;
    s8_x1 <= s7_x1;
    s8_y1 <= s7_y1;
  end

  // Divider: entry stage flags quotients too large for the quotient register,
  // then one quotient bit per stage, most significant first.
  logic              dv_v    [0:QBITS];
  logic [RW-1:0]     dv_remx [0:QBITS];
  logic [RW-1:0]     dv_remy [0:QBITS];
  logic [QBITS-1:0]  dv_qx   [0:QBITS];
  logic [QBITS-1:0]  dv_qy   [0:QBITS];
  logic [67:0]       dv_d2   [0:QBITS];
  div_side_t         dv_side [0:QBITS];
  logic [RW-1:0]     d2_top;

  assign d2_top = RW'(s8_d2) << QBITS;

  always_ff @(posedge clk) begin
    if (rst) dv_v[0] <= 1'b0;
    else     dv_v[0] <= v8;
    dv_remx[0] <= RW'(s8_nx);
    dv_remy[0] <= RW'(s8_ny);
    dv_qx[0]   <= '0;
    dv_qy[0]   <= '0;
    dv_d2[0]   <= s8_d2;
    dv_side[0] <= '{x1: s8_x1, y1: s8_y1, coll: s8_coll, negx: s8_negx,
                    negy: s8_negy, ovfx: (RW'(s8_nx) >= d2_top),
                    ovfy: (RW'(s8_ny) >= d2_top)};
  end

  for (genvar j = 0; j < QBITS; j++) begin : g_div
    localparam int Sh = QBITS - 1 - j;
    logic [RW-1:0] trx;
    assign trx = RW'(dv_d2[j]) << Sh;

    always_ff @(posedge clk) begin
      if (rst) dv_v[j+1] <= 1'b0;
      else     dv_v[j+1] <= dv_v[j];
      dv_d2[j+1]   <= dv_d2[j];
      dv_side[j+1] <= dv_side[j];
      if (dv_remx[j] >= trx) begin
        dv_remx[j+1] <= dv_remx[j] - trx;
        dv_qx[j+1]   <= {dv_qx[j][QBITS-2:0], 1'b1};
      end else begin
        dv_remx[j+1] <= dv_remx[j];
        dv_qx[j+1]   <= {dv_qx[j][QBITS-2:0], 1'b0};
      end
      if (dv_remy[j] >= trx) begin
        dv_remy[j+1] <= dv_remy[j] - trx;
        dv_qy[j+1]   <= {dv_qy[j][QBITS-2:0], 1'b1};
      end else begin
        dv_remy[j+1] <= dv_remy[j];
        dv_qy[j+1]   <= {dv_qy[j][QBITS-2:0], 1'b0};
      end
    end
  end

  // Stage A: cap the quotient magnitudes at 2^34.
  localparam logic [QBITS-1:0] QCAP = QBITS'(1) << (QBITS - 1);

  logic              va;
  logic [QBITS-1:0]  sa_mx, sa_my;
  div_side_t         sa_side;
  div_side_t         dv_last;

  assign dv_last = dv_side[QBITS];

  always_ff @(posedge clk) begin
    if (rst) va <= 1'b0;
    else     va <= dv_v[QBITS];
    sa_mx <= (dv_last.ovfx || dv_qx[QBITS] > QCAP) ? QCAP : dv_qx[QBITS];
    sa_my <= (dv_last.ovfy || dv_qy[QBITS] > QCAP) ? QCAP : dv_qy[QBITS];
    sa_side <= dv_last;
  end

  // Stage B: center with clamping, squares of the offsets.
  logic signed [36:0] cxw, cyw;
  logic               vb;
  logic signed [31:0] sb_cx, sb_cy;
  logic               sb_sat, sb_coll, sb_big;
  logic [63:0]        sb_sqx, sb_sqy;

  assign cxw = 37'(sa_side.x1) + (sa_side.negx ? -37'(sa_mx) : 37'(sa_mx));
  assign cyw = 37'(sa_side.y1) + (sa_side.negy ? -37'(sa_my) : 37'(sa_my));

  function automatic logic signed [31:0] clamp32(input logic signed [36:0] v);
    if (v > 37'sh0_7FFF_FFFF)       clamp32 = 32'sh7FFF_FFFF;
    else if (v < -37'sh0_8000_0000) clamp32 = 32'sh8000_0000;
    else                            clamp32 = v[31:0];
  endfunction

  function automatic logic out32(input logic signed [36:0] v);
    out32 = (v > 37'sh0_7FFF_FFFF) || (v < -37'sh0_8000_0000);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) vb <= 1'b0;
    else     vb <= va;
    sb_cx   <= clamp32(cxw);
    sb_cy   <= clamp32(cyw);
    sb_sat  <= out32(cxw) || out32(cyw);
    sb_coll <= sa_side.coll;
    sb_big  <= (sa_mx[QBITS-1:32] != '0) || (sa_my[QBITS-1:32] != '0);
    sb_sqx  <= sa_mx[31:0] * sa_mx[31:0];
    sb_sqy  <= sa_my[31:0] * sa_my[31:0];
  end

  // Stage C: sum of squares; a sum of 2^64 or more saturates the radius.
  logic [64:0] sqsum;
  assign sqsum = {1'b0, sb_sqx} + {1'b0, sb_sqy};

  logic        sq_v    [0:SBITS];
  logic [63:0] sq_s    [0:SBITS];
  logic [35:0] sq_rem  [0:SBITS];
  logic [31:0] sq_root [0:SBITS];
  sqrt_side_t  sq_side [0:SBITS];

  always_ff @(posedge clk) begin
    if (rst) sq_v[0] <= 1'b0;
    else     sq_v[0] <= vb;
    sq_s[0]    <= sqsum[63:0];
    sq_rem[0]  <= '0;
    sq_root[0] <= '0;
    sq_side[0] <= '{cx: sb_cx, cy: sb_cy, sat: sb_sat, coll: sb_coll,
                    radsat: sb_big || sqsum[64]};
  end

  // Square root, one root bit per stage; two radicand bits shift in each time.
  for (genvar k = 0; k < SBITS; k++) begin : g_sqrt
    logic [35:0] rsh, trl;
    assign rsh = {sq_rem[k][33:0], sq_s[k][63:62]};
    assign trl = {2'b00, sq_root[k], 2'b01};

    always_ff @(posedge clk) begin
      if (rst) sq_v[k+1] <= 1'b0;
      else     sq_v[k+1] <= sq_v[k];
      sq_s[k+1]    <= {sq_s[k][61:0], 2'b00};
      sq_side[k+1] <= sq_side[k];
      if (rsh >= trl) begin
        sq_rem[k+1]  <= rsh - trl;
        sq_root[k+1] <= {sq_root[k][30:0], 1'b1};
      end else begin
        sq_rem[k+1]  <= rsh;
        sq_root[k+1] <= {sq_root[k][30:0], 1'b0};
      end
    end
  end

  // Output stage: round the root, saturate, pick the status.
  sqrt_side_t  fin;
  logic [32:0] rnd;
  logic [31:0] rad;

  assign fin = sq_side[SBITS];
  assign rnd = {1'b0, sq_root[SBITS]} +
               33'(sq_rem[SBITS] > 36'(sq_root[SBITS]));
  assign rad = (fin.radsat || rnd[32]) ? 32'hFFFF_FFFF : rnd[31:0];

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= sq_v[SBITS];
    if (fin.coll) begin
      center_x      <= '0;
      center_y      <= '0;
      circle_radius <= '0;
      status        <= ST_COLL;
    end else begin
      center_x      <= fin.cx;
      center_y      <= fin.cy;
      circle_radius <= rad;
      priority if (rad < min_rad) status <= ST_SMALL;
      else if (fin.sat)           status <= ST_SAT;
      else                        status <= ST_OK;
    end
  end

`ifndef SYNTHESIS
  a_coll_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_COLL) |->
      (center_x == '0 && center_y == '0 && circle_radius == '0))
    else $error("collinear result carries a nonzero center or radius");

  a_ok_radius: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_OK) |-> (circle_radius >= $past(min_rad)))
    else $error("radius below the minimum reported as ok");

  a_sat_bound: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_SAT) |->
      (center_x == 32'sh7FFF_FFFF || center_x == 32'sh8000_0000 ||
       center_y == 32'sh7FFF_FFFF || center_y == 32'sh8000_0000))
    else $error("saturated status without a clamped center");
`endif

endmodule
`default_nettype wire

/* tb/sv/circumcircle_from_three_points_test.sv */
// Self-checking testbench for the circumcircle pipeline: directed table, then random triples.
`timescale 1ns / 1ps
module circumcircle_from_three_points_test;
  import ccirc_pkg::*;

  typedef struct {
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic [31:0]        rad;
    logic [1:0]         st;
  } circle_t;

  typedef struct {
    logic signed [31:0] p [6];
    logic               typed;
    circle_t            want;
  } row_t;

  logic clk, rst, start, busy, cfg_we, cfg_index, done;
  logic signed [31:0] first_x, first_y, second_x, second_y, third_x, third_y;
  logic [31:0] cfg_data;
  logic signed [31:0] center_x, center_y;
  logic [31:0] circle_radius;
  logic [1:0] status;

  logic [31:0] coll_thr, min_rad;
  circle_t circle_q[$];
  int errors;
  int idle_pct;

  circumcircle_from_three_points u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .first_x(first_x), .first_y(first_y), .second_x(second_x), .second_y(second_y),
    .third_x(third_x), .third_y(third_y),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .done(done), .center_x(center_x), .center_y(center_y),
    .circle_radius(circle_radius), .status(status)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("RESULT: ERROR");
    $finish;
  end

  // round(num / (2*den)), ties away from zero, magnitude capped at 2^34
  function automatic longint half_quot(logic signed [127:0] num, logic signed [127:0] den);
    logic [127:0] an, ad, m;
    an = num[127] ? -num : num;
    ad = den[127] ? -den : den;
    m = (an + ad) / (ad << 1);
    if (m > (128'd1 << 34)) m = 128'd1 << 34;
    return (num[127] ^ den[127]) ? -longint'(m[63:0]) : longint'(m[63:0]);
  endfunction

  function automatic logic [31:0] round_radius(longint ux, longint uy);
    logic [127:0] mx, my, s, r, t;
    mx = ux < 0 ? -128'(ux) : 128'(ux);
    my = uy < 0 ? -128'(uy) : 128'(uy);
    if (mx >= (128'd1 << 32) || my >= (128'd1 << 32)) return 32'hFFFFFFFF;
    s = mx * mx + my * my;
    if (s >= (128'd1 << 64)) return 32'hFFFFFFFF;
    r = '0;
    for (int b = 32; b >= 0; b--) begin
      t = r | (128'd1 << b);
      if (t * t <= s) r = t;
    end
    if (s - r * r > r) r = r + 128'd1;
    return r > 128'hFFFFFFFF ? 32'hFFFFFFFF : r[31:0];
  endfunction

  function automatic circle_t predict_circle(logic signed [31:0] p [6]);
    longint x1, y1, ux, uy, cx, cy;
    logic signed [127:0] ax, ay, bx, by, det, sa, sb;
    logic [127:0] adet;
    logic sat;
    logic [31:0] rad;
    circle_t c;
    x1 = longint'(p[0]);
    y1 = longint'(p[1]);
    ax = 128'(longint'(p[2]) - x1);
    ay = 128'(longint'(p[3]) - y1);
    bx = 128'(longint'(p[4]) - x1);
    by = 128'(longint'(p[5]) - y1);
    det = ax * by - ay * bx;
    sa = ax * ax + ay * ay;
    sb = bx * bx + by * by;
    adet = det[127] ? -det : det;
    if (adet == 0 || adet < {96'd0, coll_thr}) begin
      c.cx = '0; c.cy = '0; c.rad = '0; c.st = ST_COLL;
      return c;
    end
    ux = half_quot(by * sa - ay * sb, det);
    uy = half_quot(ax * sb - bx * sa, det);
    sat = 1'b0;
    cx = x1 + ux;
    cy = y1 + uy;
    if (cx > 64'sd2147483647) begin cx = 2147483647; sat = 1'b1; end
    if (cx < -64'sd2147483648) begin cx = -2147483648; sat = 1'b1; end
    if (cy > 64'sd2147483647) begin cy = 2147483647; sat = 1'b1; end
    if (cy < -64'sd2147483648) begin cy = -2147483648; sat = 1'b1; end
    rad = round_radius(ux, uy);
    c.cx = cx[31:0];
    c.cy = cy[31:0];
    c.rad = rad;
    c.st = rad < min_rad ? ST_SMALL : (sat ? ST_SAT : ST_OK);
    return c;
  endfunction

  task automatic send_triple(logic signed [31:0] p [6], logic typed, circle_t want);
    start <= 1'b1;
    first_x <= p[0]; first_y <= p[1];
    second_x <= p[2]; second_y <= p[3];
    third_x <= p[4]; third_y <= p[5];
    @(posedge clk);
    while (busy) @(posedge clk);
    circle_q.push_back(typed ? want : predict_circle(p));
    if ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  // The enable drops for one cycle after each write.
  task automatic write_reg(logic idx, logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_COLL_THR) coll_thr = val; else min_rad = val;
    @(posedge clk);
  endtask

  task automatic drain;
    start <= 1'b0;
    while (circle_q.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  // Random triple; most shapes are small and near a circle so that all status codes occur.
  task automatic random_triple(output logic signed [31:0] p [6]);
    longint base_x, base_y, span, k;
    case ($urandom_range(0, 9))
      0, 1, 2: for (int i = 0; i < 6; i++) p[i] = $urandom;
      3, 4, 5, 6: begin
        base_x = $signed($urandom);
        base_y = $signed($urandom);
        span = longint'(1) << $urandom_range(0, 26);
        for (int i = 0; i < 6; i++)
          p[i] = 32'(((i % 2) ? base_y : base_x) +
                     longint'($urandom_range(0, 2 * span)) - span);
      end
      7, 8: begin
        // Points on a line, with a tiny jitter on the third in three cases of four.
        base_x = $signed($urandom);
        base_y = $signed($urandom);
        span = longint'(1) << $urandom_range(0, 20);
        p[0] = 32'(base_x); p[1] = 32'(base_y);
        p[2] = 32'(base_x + longint'($urandom_range(0, 2 * span)) - span);
        p[3] = 32'(base_y + longint'($urandom_range(0, 2 * span)) - span);
        k = longint'($urandom_range(0, 6)) - 3;
        p[4] = 32'(base_x + k * (longint'(p[2]) - base_x) + longint'($urandom_range(0, 1)));
        p[5] = 32'(base_y + k * (longint'(p[3]) - base_y) + longint'($urandom_range(0, 1)));
      end
      default: begin
        base_x = $signed($urandom);
        base_y = $signed($urandom);
        for (int i = 0; i < 6; i++)
          p[i] = 32'(((i % 2) ? base_y : base_x) + longint'($urandom_range(0, 200)) - 100);
      end
    endcase
  endtask

  always @(posedge clk) begin
    circle_t w;
    if (!rst && done) begin
      if (circle_q.size() == 0) begin
        $display("%0t: result beat with none expected: %h %h %h %0d", $time,
                 center_x, center_y, circle_radius, status);
        errors++;
      end else begin
        w = circle_q.pop_front();
        if (center_x !== w.cx || center_y !== w.cy || circle_radius !== w.rad ||
            status !== w.st) begin
          $display("%0t: mismatch expected %h %h %h %0d actual %h %h %h %0d", $time,
                   w.cx, w.cy, w.rad, w.st, center_x, center_y, circle_radius, status);
          errors++;
        end
      end
    end
  end

  localparam logic signed [31:0] MX = 32'sh7FFFFFFF;
  localparam logic signed [31:0] MN = 32'sh80000000;
  localparam logic signed [31:0] ONE = 32'sh00010000;

  initial begin
    row_t rows [$];
    circle_t coll_zero;
    logic signed [31:0] p [6];
    logic [31:0] thr_set [4];
    logic [31:0] rad_set [4];

    rst = 1'b1; start = 1'b0; cfg_we = 1'b0; cfg_index = 1'b0; cfg_data = '0;
    first_x = '0; first_y = '0; second_x = '0; second_y = '0; third_x = '0; third_y = '0;
    errors = 0;
    idle_pct = 10;
    coll_thr = COLL_THR_RESET;
    min_rad = MIN_RAD_RESET;
    coll_zero = '{cx: 0, cy: 0, rad: 0, st: ST_COLL};
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Some degenerate inputs are typed in; the rest go through the predictor.
    rows.push_back('{p: '{0, 0, 0, 0, 0, 0}, typed: 1, want: coll_zero});
    rows.push_back('{p: '{MX, MX, MX, MX, MX, MX}, typed: 1, want: coll_zero});
    rows.push_back('{p: '{MN, MN, MN, MN, MN, MN}, typed: 1, want: coll_zero});
    rows.push_back('{p: '{0, 0, ONE, ONE, 2 * ONE, 2 * ONE}, typed: 1, want: coll_zero});
    rows.push_back('{p: '{MN, MN, 0, 0, MX, MX}, typed: 0, want: coll_zero});
    rows.push_back('{p: '{0, 0, 1, 0, 0, 1}, typed: 1, want: coll_zero});
    rows.push_back('{p: '{0, 0, 2 * ONE, 0, 0, 2 * ONE}, typed: 0, want: coll_zero});
    rows.push_back('{p: '{0, 0, 100, 0, 0, 100}, typed: 0, want: coll_zero});
    rows.push_back('{p: '{MN, MN, MX, MN, MN, MX}, typed: 0, want: coll_zero});
    rows.push_back('{p: '{MX, MX, MN, MX, MX, MN}, typed: 0, want: coll_zero});
    rows.push_back('{p: '{MX, 0, MX, ONE, MX - ONE, 0}, typed: 0, want: coll_zero});
    rows.push_back('{p: '{0, 0, ONE, 0, 2 * ONE, 1}, typed: 0, want: coll_zero});
    rows.push_back('{p: '{0, 0, MX, 0, MX, 1}, typed: 0, want: coll_zero});
    rows.push_back('{p: '{-ONE, 0, ONE, 0, 0, ONE}, typed: 0, want: coll_zero});
    rows.push_back('{p: '{5, 7, 5, 7, 9, 9}, typed: 1, want: coll_zero});
    rows.push_back('{p: '{0, 0, 3, 0, 0, 4000}, typed: 0, want: coll_zero});
    foreach (rows[i]) send_triple(rows[i].p, rows[i].typed, rows[i].want);
    drain();

    thr_set = '{32'd0, 32'hFFFFFFFF, COLL_THR_RESET, 32'd0};
    rad_set = '{32'd0, 32'hFFFFFFFF, MIN_RAD_RESET, 32'd0};
    for (int ph = 0; ph < 6; ph++) begin
      idle_pct = ph < 2 ? 10 : (ph < 4 ? 60 : 0);
      write_reg(CFG_COLL_THR, ph < 4 ? thr_set[ph] : $urandom_range(0, 1 << 20));
      write_reg(CFG_MIN_RAD, ph < 4 ? rad_set[ph] : $urandom_range(0, 1 << 24));
      for (int n = 0; n < 250; n++) begin
        random_triple(p);
        send_triple(p, 1'b0, coll_zero);
      end
      drain();
    end

    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
